>>> src/cflc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_pkg
// Shared sizes, types and saturating helpers for the leaf clustering core.
// ----------------------------------------------------------------------------
package cflc_pkg;

    localparam int CAPACITY = 1024;
    localparam int MAX_DIM  = 8;
    localparam int CAP_W    = $clog2(CAPACITY);
    localparam int CNT_W    = CAP_W + 1;
    localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ND_W     = $clog2(MAX_DIM + 1);

    localparam logic [31:0] THR_MIN    = 32'd655;
    localparam logic [31:0] THR_RESET  = 32'd65536;
    localparam logic [9:0]  MAXE_MIN   = 10'd100;
    localparam logic [9:0]  MAXE_RESET = 10'd100;
    localparam logic [3:0]  DIMS_RESET = 4'd2;

    typedef enum logic [1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_MAX_ENTRIES = 2'd1,
        CFG_DIMS        = 2'd2
    } t_cfg_index;

    typedef logic [MAX_DIM-1:0][31:0] t_point;
    typedef logic [MAX_DIM-1:0][63:0] t_sum_row;

    typedef struct packed {
        logic [31:0]     threshold;
        logic [CNT_W-1:0] eff_max;
        logic [ND_W-1:0]  nd;
    } t_cfg;

    typedef struct packed {
        logic [CAP_W-1:0] entry_index;
        logic             absorbed;
        logic             rebuilt;
        logic [CNT_W-1:0] entry_count;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DRD, ST_DMUL, ST_DACC, ST_DCMP, ST_DECIDE,
        ST_URD, ST_UWR, ST_AWR, ST_CSTART, ST_CWAIT, ST_CWR,
        ST_RBCHK, ST_RBRI, ST_RBLI, ST_MRJ, ST_MLJ, ST_MRI, ST_MWI,
        ST_SHR, ST_SHW, ST_OUT
    } t_state;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

endpackage

>>> src/cflc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_front
// Point assembler: gathers coordinates into a point and pushes whole points.
// ----------------------------------------------------------------------------
module cflc_front import cflc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ND_W-1:0] i_nd,
    input  logic            i_accept,
    input  logic [31:0]     i_coord,
    input  logic            i_last_coord,
    output logic            o_push,
    output t_point          o_point
);

    t_point     r_buf;
    t_point     n_buf;
    logic [3:0] r_cnt;

    always_comb begin
        n_buf = r_buf;
        if (int'(r_cnt) < int'(i_nd)) begin
            n_buf[r_cnt[DIM_W-1:0]] = i_coord;
        end
    end

    assign o_push  = i_accept && i_last_coord;
    assign o_point = n_buf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            if (i_last_coord) begin
                r_buf <= '0;
                r_cnt <= '0;
            end else begin
                r_buf <= n_buf;
                if (r_cnt != 4'hF) begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
        end
    end

endmodule

>>> src/cflc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_queue
// Two-deep point queue between assembler and sequencer.
// ----------------------------------------------------------------------------
module cflc_queue import cflc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_point,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_point o_point
);

    t_point     r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_point = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> src/cflc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_div
// Radix-2 centroid divider: signed 64-bit sum by 32-bit count, clamped.
// ----------------------------------------------------------------------------
module cflc_div import cflc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);

    logic        r_busy;
    logic [6:0]  r_step;
    logic        r_neg;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [32:0] rem2;
    logic        take;

    assign rem2 = {r_rem[31:0], r_quo[63]};
    assign take = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_neg  <= i_num[63];
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= i_num[63] ? (~i_num + 64'd1) : i_num;
                r_step <= '0;
                if (i_den == 32'd0) begin
                    o_quo  <= '0;
                    o_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_step == 7'd64) begin
                    // clamp the magnitude to the signed 32-bit range
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    if (r_neg) begin
                        o_quo <= (r_quo > 64'h8000_0000) ? 32'h8000_0000
                                                          : (~r_quo[31:0] + 32'd1);
                    end else begin
                        o_quo <= (r_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_quo[31:0];
                    end
                end else begin
                    r_rem  <= take ? (rem2 - {1'b0, r_den}) : rem2;
                    r_quo  <= {r_quo[62:0], take};
                    r_step <= r_step + 7'd1;
                end
            end
        end
    end

endmodule

>>> src/cflc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_back
// Table sequencer: nearest-entry search, absorb or append, merging rebuild.
// ----------------------------------------------------------------------------
module cflc_back import cflc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_point  i_q_point,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_state r_state, n_state;

    // table memories
    logic [31:0] mem_cnt [CAPACITY];
    t_sum_row    mem_sum [CAPACITY];
    t_point      mem_cen [CAPACITY];

    logic [31:0] rd_cnt;
    t_sum_row    rd_sum;
    t_point      rd_cen;

    logic             re, we_cs, we_cen, div_start;
    logic [CAP_W-1:0] raddr, waddr;
    logic [31:0]      wcnt;
    t_sum_row         wsum;
    t_point           wcen;

    t_point           r_ra;
    logic [63:0]      r_thr2, r_acc, r_best;
    logic [64:0]      r_sq;
    logic [DIM_W-1:0] r_d;
    logic [CNT_W-1:0] r_used, r_i, r_j, r_k;
    logic [CAP_W-1:0] r_idx, r_bi, r_bj, r_tgt;
    logic             r_found, r_rb, r_absorbed, r_rebuilt;
    logic [31:0]      r_ocnt, r_ucnt;
    t_sum_row         r_osum, r_usum;
    t_point           r_crow;

    logic        div_done;
    logic [31:0] div_quo;

    logic [32:0] diff, mag;
    logic [65:0] sq_full;
    logic [64:0] acc_sum;
    logic [63:0] acc_next;
    logic        last_d, better, rb_more;
    logic [CNT_W-1:0] half;

    assign diff     = {r_ra[r_d][31], r_ra[r_d]} - {rd_cen[r_d][31], rd_cen[r_d]};
    assign mag      = diff[32] ? (~diff + 33'd1) : diff;
    assign sq_full  = {33'd0, mag} * {33'd0, mag};
    assign acc_sum  = {1'b0, r_acc} + r_sq;
    assign acc_next = acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
    assign last_d   = ({1'b0, r_d} == ND_W'(i_cfg.nd - 1'b1)) || (int'(r_d) == MAX_DIM - 1);
    assign better   = !r_found || (r_acc < r_best);
    assign half     = i_cfg.eff_max >> 1;
    assign rb_more  = (r_used > half) && (r_used >= CNT_W'(2));

    cflc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_usum[r_d]),
        .i_den   (r_ucnt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_q_valid) n_state = (r_used == '0) ? ST_DECIDE : ST_DRD;
            ST_DRD:    n_state = ST_DMUL;
            ST_DMUL:   n_state = ST_DACC;
            ST_DACC:   n_state = last_d ? ST_DCMP : ST_DMUL;
            ST_DCMP: begin
                if (!r_rb) begin
                    n_state = (r_j + 1'b1 == r_used) ? ST_DECIDE : ST_DRD;
                end else if (r_j + 1'b1 < r_used) begin
                    n_state = ST_DRD;
                end else if (r_i + CNT_W'(2) < r_used) begin
                    n_state = ST_RBRI;
                end else begin
                    n_state = ST_MRJ;
                end
            end
            ST_DECIDE: n_state = (r_found && r_best <= r_thr2) ? ST_URD : ST_AWR;
            ST_URD:    n_state = ST_UWR;
            ST_UWR:    n_state = ST_CSTART;
            ST_AWR:    n_state = ST_CSTART;
            ST_CSTART: n_state = ST_CWAIT;
            ST_CWAIT:  if (div_done) n_state = (int'(r_d) == MAX_DIM - 1) ? ST_CWR : ST_CSTART;
            ST_CWR: begin
                if (r_rb)                        n_state = ST_SHR;
                else if (r_used > i_cfg.eff_max) n_state = ST_RBCHK;
                else                             n_state = ST_OUT;
            end
            ST_RBCHK:  n_state = rb_more ? ST_RBRI : ST_OUT;
            ST_RBRI:   n_state = ST_RBLI;
            ST_RBLI:   n_state = ST_DRD;
            ST_MRJ:    n_state = ST_MLJ;
            ST_MLJ:    n_state = ST_MRI;
            ST_MRI:    n_state = ST_MWI;
            ST_MWI:    n_state = ST_CSTART;
            ST_SHR:    n_state = (r_k + 1'b1 < r_used) ? ST_SHW : ST_RBCHK;
            ST_SHW:    n_state = ST_SHR;
            ST_OUT:    if (!o_valid || i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        re        = 1'b0;
        we_cs     = 1'b0;
        we_cen    = 1'b0;
        div_start = 1'b0;
        raddr     = r_j[CAP_W-1:0];
        waddr     = r_idx;
        wcnt      = rd_cnt;
        wsum      = rd_sum;
        wcen      = rd_cen;
        o_q_pop   = 1'b0;
        case (r_state)
            ST_IDLE:   o_q_pop = i_q_valid;
            ST_DRD:    re = 1'b1;
            ST_RBRI: begin
                re    = 1'b1;
                raddr = r_i[CAP_W-1:0];
            end
            ST_URD: begin
                re    = 1'b1;
                raddr = r_idx;
            end
            ST_UWR: begin
                we_cs = 1'b1;
                wcnt  = sat_add32(rd_cnt, 32'd1);
                for (int d = 0; d < MAX_DIM; d++) begin
                    wsum[d] = sat_add64(rd_sum[d], {{32{r_ra[d][31]}}, r_ra[d]});
                end
            end
            ST_AWR: begin
                we_cs = 1'b1;
                waddr = r_used[CAP_W-1:0];
                wcnt  = 32'd1;
                for (int d = 0; d < MAX_DIM; d++) begin
                    wsum[d] = {{32{r_ra[d][31]}}, r_ra[d]};
                end
            end
            ST_MRJ: begin
                re    = 1'b1;
                raddr = r_bj;
            end
            ST_MRI: begin
                re    = 1'b1;
                raddr = r_bi;
            end
            ST_MWI: begin
                we_cs = 1'b1;
                waddr = r_bi;
                wcnt  = sat_add32(rd_cnt, r_ocnt);
                for (int d = 0; d < MAX_DIM; d++) begin
                    wsum[d] = sat_add64(rd_sum[d], r_osum[d]);
                end
            end
            ST_CSTART: div_start = 1'b1;
            ST_CWR: begin
                we_cen = 1'b1;
                waddr  = r_tgt;
                wcen   = r_crow;
            end
            ST_SHR: begin
                re    = (r_k + 1'b1 < r_used);
                raddr = CAP_W'(r_k + 1'b1);
            end
            ST_SHW: begin
                we_cs  = 1'b1;
                we_cen = 1'b1;
                waddr  = r_k[CAP_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            rd_cnt <= mem_cnt[raddr];
            rd_sum <= mem_sum[raddr];
            rd_cen <= mem_cen[raddr];
        end
        if (we_cs) begin
            mem_cnt[waddr] <= wcnt;
            mem_sum[waddr] <= wsum;
        end
        if (we_cen) begin
            mem_cen[waddr] <= wcen;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ra    <= i_q_point;
                r_thr2  <= {32'd0, i_cfg.threshold} * {32'd0, i_cfg.threshold};
                r_j     <= '0;
                r_found <= 1'b0;
                r_rb    <= 1'b0;
            end
            ST_DRD: begin
                r_d   <= '0;
                r_acc <= '0;
            end
            ST_DMUL:  r_sq <= sq_full[64:0];
            ST_DACC: begin
                r_acc <= acc_next;
                if (!last_d) r_d <= r_d + 1'b1;
            end
            ST_DCMP: begin
                if (better) begin
                    r_best  <= r_acc;
                    r_found <= 1'b1;
                    if (r_rb) begin
                        r_bi <= r_i[CAP_W-1:0];
                        r_bj <= r_j[CAP_W-1:0];
                    end else begin
                        r_idx <= r_j[CAP_W-1:0];
                    end
                end
                if (!r_rb || r_j + 1'b1 < r_used) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            ST_DECIDE: begin
                r_absorbed <= r_found && r_best <= r_thr2;
                r_rebuilt  <= 1'b0;
                if (!(r_found && r_best <= r_thr2)) r_idx <= r_used[CAP_W-1:0];
            end
            ST_UWR, ST_AWR, ST_MWI: begin
                r_ucnt <= wcnt;
                r_usum <= wsum;
                r_tgt  <= waddr;
                r_d    <= '0;
            end
            ST_CWAIT: begin
                if (div_done) begin
                    r_crow[r_d] <= div_quo;
                    if (int'(r_d) != MAX_DIM - 1) r_d <= r_d + 1'b1;
                end
            end
            ST_CWR: begin
                r_k <= {1'b0, r_bj};
                if (!r_rb && r_used > i_cfg.eff_max) begin
                    r_rb      <= 1'b1;
                    r_rebuilt <= 1'b1;
                end
            end
            ST_RBCHK: begin
                r_i     <= '0;
                r_found <= 1'b0;
            end
            ST_RBLI: begin
                r_ra <= rd_cen;
                r_j  <= r_i + 1'b1;
            end
            ST_MLJ: begin
                r_ocnt <= rd_cnt;
                r_osum <= rd_sum;
            end
            ST_SHW:   r_k <= r_k + 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (r_state == ST_AWR) r_used <= r_used + 1'b1;
            if (r_state == ST_SHR && !(r_k + 1'b1 < r_used)) r_used <= r_used - 1'b1;
            if (r_state == ST_OUT && (!o_valid || i_ready)) begin
                o_valid           <= 1'b1;
                o_res.entry_index <= r_idx;
                o_res.absorbed    <= r_absorbed;
                o_res.rebuilt     <= r_rebuilt;
                o_res.entry_count <= r_used;
            end
        end
    end

endmodule

>>> src/cf_leaf_clustering_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cf_leaf_clustering_insert_core
// Flat clustering-feature table: absorbs or appends points, merges on overflow.
// ----------------------------------------------------------------------------
// Coordinates stream in one word per handshake; the word with last_coord set
// closes a point, which goes through a two-deep queue to the table sequencer.
// For each point the nearest search visits every table entry, forming one
// squared term at a time through a single multiplier; the touched entry's
// centroids are then refreshed through the shared radix-2 divider. A rebuild
// searches every entry pair per merge, then does one divider refresh and a
// shift sweep of the tail of the table per merge. The table memories start
// undefined and need no clearing pass; only entries below the fill count
// are ever read.
module cf_leaf_clustering_insert_core import cflc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [31:0] i_coord,
    input  logic              i_last_coord,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CAP_W-1:0]  o_entry_index,
    output logic              o_absorbed,
    output logic              o_rebuilt,
    output logic [CNT_W-1:0]  o_entry_count,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    logic [31:0] r_threshold;
    logic [9:0]  r_max_entries;
    logic [3:0]  r_dims;
    t_cfg        cfg;

    logic    push, q_full, q_valid, q_pop;
    t_point  push_point, q_point;
    t_result res;

    // take config words at any time; the host must write only while idle, the block does not check it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THR_RESET;
            r_max_entries <= MAXE_RESET;
            r_dims        <= DIMS_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_THRESHOLD:   r_threshold   <= (i_cfg_data < THR_MIN) ? THR_MIN : i_cfg_data;
                CFG_MAX_ENTRIES: r_max_entries <= (i_cfg_data[9:0] < MAXE_MIN) ? MAXE_MIN
                                                                             : i_cfg_data[9:0];
                CFG_DIMS:        r_dims        <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp dims to 1..MAX_DIM and the limit to the table size minus one
    always_comb begin
        cfg.threshold = r_threshold;
        cfg.eff_max   = (int'(r_max_entries) > CAPACITY - 1) ? CNT_W'(CAPACITY - 1)
                                                              : CNT_W'(r_max_entries);
        if (r_dims == 4'd0)                   cfg.nd = ND_W'(1);
        else if (int'(r_dims) > MAX_DIM)      cfg.nd = ND_W'(MAX_DIM);
        else                                  cfg.nd = ND_W'(r_dims);
    end

    // stall the coordinate stream only when the point queue is full
    assign o_in_ready = !q_full;

    cflc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nd         (cfg.nd),
        .i_accept     (i_in_valid && o_in_ready),
        .i_coord      (i_coord),
        .i_last_coord (i_last_coord),
        .o_push       (push),
        .o_point      (push_point)
    );

    cflc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_point (push_point),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_point (q_point)
    );

    cflc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_point (q_point),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_res     (res)
    );

    assign o_entry_index = res.entry_index;
    assign o_absorbed    = res.absorbed;
    assign o_rebuilt     = res.rebuilt;
    assign o_entry_count = res.entry_count;

endmodule

>>> src/cflc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cflc_checker
// Port-level checks on the result stream of the clustering core.
// ----------------------------------------------------------------------------
module cflc_checker import cflc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [CAP_W-1:0] o_entry_index,
    input logic             o_absorbed,
    input logic             o_rebuilt,
    input logic [CNT_W-1:0] o_entry_count
);

    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entry_index)
            && $stable(o_entry_count) && $stable(o_absorbed))
        else $error("stalled result changed");

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count != '0)
        else $error("empty table after a point");

    // a fresh entry without rebuild lands at the end of the table
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_absorbed && !o_rebuilt |->
            o_entry_count == CNT_W'(o_entry_index) + CNT_W'(1))
        else $error("appended entry not last");

    a_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rebuilt |-> int'(o_entry_count) <= (CAPACITY - 1) / 2)
        else $error("rebuild left too many entries");

endmodule

bind cf_leaf_clustering_insert_core cflc_checker u_cflc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_entry_index (o_entry_index),
    .o_absorbed    (o_absorbed),
    .o_rebuilt     (o_rebuilt),
    .o_entry_count (o_entry_count)
);

>>> dv/cluster_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_scoreboard
// Tracks the leaf clustering table. Predicts one result per closed point and
// checks the results that come back.
// ----------------------------------------------------------------------------
import cflc_pkg::*;

class ClusterScoreboard;

    // register copies
    bit [31:0] thr;
    bit [9:0]  max_ent;
    bit [3:0]  dims_raw;

    // table copy
    bit signed [31:0] pbuf [MAX_DIM];
    int unsigned      ccnt;
    int unsigned      used;
    bit [31:0]        cnt  [CAPACITY];
    longint           lsum [CAPACITY][MAX_DIM];
    longint           cen  [CAPACITY][MAX_DIM];

    t_result pending_q[$];
    int      errors;

    function new();
        thr      = THR_RESET;
        max_ent  = MAXE_RESET;
        dims_raw = DIMS_RESET;
        ccnt     = 0;
        used     = 0;
        errors   = 0;
        foreach (pbuf[d]) pbuf[d] = 0;
    endfunction

    function void write_reg(t_cfg_index idx, bit [31:0] data);
        case (idx)
            CFG_THRESHOLD:   thr = (data < 655) ? 32'd655 : data;
            CFG_MAX_ENTRIES: max_ent = (data[9:0] < 100) ? 10'd100 : data[9:0];
            CFG_DIMS:        dims_raw = data[3:0];
            default: ;
        endcase
    endfunction

    function int unsigned nd();
        if (dims_raw < 1) return 1;
        if (dims_raw > MAX_DIM) return MAX_DIM;
        return dims_raw;
    endfunction

    function int unsigned eff_max();
        if (max_ent > CAPACITY - 1) return CAPACITY - 1;
        return max_ent;
    endfunction

    function longint add_sat64(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function bit [31:0] add_sat32(bit [31:0] a, bit [31:0] b);
        bit [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function longint mean_of(int unsigned e, int unsigned d);
        longint q;
        if (cnt[e] == 0) return 0;
        q = lsum[e][d] / longint'({32'd0, cnt[e]});
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function bit [63:0] add_square(bit [63:0] acc, longint diff);
        bit [63:0] m;
        bit [64:0] s;
        m = (diff < 0) ? -diff : diff;
        s = {1'b0, acc} + {1'b0, m * m};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // merge closest pairs until the table is at most half the limit
    function void merge_table();
        int unsigned n, half, i, j, d, bi, bj;
        bit [63:0] best, acc;
        bit found;
        n = nd();
        half = eff_max() / 2;
        for (i = 0; i < used; i++)
            for (d = 0; d < MAX_DIM; d++) cen[i][d] = mean_of(i, d);
        while (used > half && used >= 2) begin
            bi = 0; bj = 1; best = '1; found = 0;
            for (i = 0; i < used; i++)
                for (j = i + 1; j < used; j++) begin
                    acc = 0;
                    for (d = 0; d < n; d++) acc = add_square(acc, cen[i][d] - cen[j][d]);
                    if (!found || acc < best) begin
                        best = acc; bi = i; bj = j; found = 1;
                    end
                end
            cnt[bi] = add_sat32(cnt[bi], cnt[bj]);
            for (d = 0; d < MAX_DIM; d++) lsum[bi][d] = add_sat64(lsum[bi][d], lsum[bj][d]);
            for (d = 0; d < MAX_DIM; d++) cen[bi][d] = mean_of(bi, d);
            for (i = bj; i + 1 < used; i++) begin
                cnt[i] = cnt[i + 1];
                for (d = 0; d < MAX_DIM; d++) begin
                    lsum[i][d] = lsum[i + 1][d];
                    cen[i][d]  = cen[i + 1][d];
                end
            end
            used--;
        end
    endfunction

    // note an accepted coordinate word; a closing word queues one result
    function void note_word(bit signed [31:0] c, bit last);
        int unsigned n, e, d, idx;
        bit [63:0] best, sq_dist, lim;
        bit found, absorbed, rebuilt;
        t_result r;
        n = nd();
        if (ccnt < n) pbuf[ccnt] = c;
        if (ccnt < 15) ccnt++;
        if (!last) return;
        found = 0; best = '1; idx = 0; absorbed = 0; rebuilt = 0;
        for (e = 0; e < used; e++) begin
            sq_dist = 0;
            for (d = 0; d < n; d++)
                sq_dist = add_square(sq_dist, longint'(pbuf[d]) - mean_of(e, d));
            if (!found || sq_dist < best) begin
                best = sq_dist; idx = e; found = 1;
            end
        end
        lim = {32'd0, thr} * {32'd0, thr};
        if (found && best <= lim) begin
            absorbed = 1;
            cnt[idx] = add_sat32(cnt[idx], 1);
            for (d = 0; d < MAX_DIM; d++) lsum[idx][d] = add_sat64(lsum[idx][d], longint'(pbuf[d]));
        end else begin
            idx = used;
            cnt[idx] = 1;
            for (d = 0; d < MAX_DIM; d++) lsum[idx][d] = longint'(pbuf[d]);
            used++;
        end
        if (used > eff_max()) begin
            merge_table();
            rebuilt = 1;
        end
        foreach (pbuf[k]) pbuf[k] = 0;
        ccnt = 0;
        r.entry_index = idx[CAP_W-1:0];
        r.absorbed    = absorbed;
        r.rebuilt     = rebuilt;
        r.entry_count = used[CNT_W-1:0];
        pending_q.push_back(r);
    endfunction

    function void check_result(t_result got);
        t_result exp_r;
        if (pending_q.size() == 0) begin
            $error("result with nothing pending: index %0d", got.entry_index);
            errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.entry_index !== exp_r.entry_index) begin
            $error("entry_index exp %0d got %0d", exp_r.entry_index, got.entry_index);
            errors++;
        end
        if (got.absorbed !== exp_r.absorbed) begin
            $error("absorbed exp %0d got %0d", exp_r.absorbed, got.absorbed);
            errors++;
        end
        if (got.rebuilt !== exp_r.rebuilt) begin
            $error("rebuilt exp %0d got %0d", exp_r.rebuilt, got.rebuilt);
            errors++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
            $error("entry_count exp %0d got %0d", exp_r.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives coordinate words into the leaf clustering core, predicts each point's
// table outcome and checks every result word against it.
// ----------------------------------------------------------------------------
module tb_top;
    import cflc_pkg::*;

    // a full rebuild at the smallest limit moves no word while it scans
    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int SETTLE_CYCLES  = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic signed [31:0] i_coord;
    logic              i_last_coord;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CAP_W-1:0]  o_entry_index;
    logic              o_absorbed;
    logic              o_rebuilt;
    logic [CNT_W-1:0]  o_entry_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [31:0]       i_cfg_data;

    ClusterScoreboard sb = new();

    // idling knobs, percent per cycle
    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    cf_leaf_clustering_insert_core DUT (.*);

    initial i_clk = 0;
    always #10 i_clk = ~i_clk;

    // Receiver: check on handshake, then pick next ready. A long hold-off is
    // counted here so the sender keeps pushing and the input backs up; it
    // outlasts several points of table search so the queue fills.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.entry_index = o_entry_index;
            got.absorbed    = o_absorbed;
            got.rebuilt     = o_rebuilt;
            got.entry_count = o_entry_count;
            sb.check_result(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 0;
            hold_left = 8000;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one coordinate word, with an optional random gap first.
    task automatic send_word(input logic [31:0] c, input bit last);
        if (send_gap_pct > 0) begin
            while ($urandom_range(99) < send_gap_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_coord      <= c;
        i_last_coord <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(c, last);
    endtask

    // Hold the sender until every expected result is back, then let the
    // core settle, since words without a result may still be in flight.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Random points: mostly well-formed near a few centers, some short or
    // long points and some full-range noise.
    task automatic random_points(input int words);
        int sent, n, k, nd;
        logic [31:0] ctr [4];
        logic [31:0] c;
        sent = 0;
        foreach (ctr[j]) ctr[j] = $urandom();
        while (sent < words) begin
            nd = sb.nd();
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : nd;
            for (k = 0; k < n; k++) begin
                if ($urandom_range(9) == 0)
                    c = $urandom();
                else
                    c = ctr[$urandom_range(3)] + $urandom_range(8191) - 4096;
                send_word(c, k == n - 1);
                sent++;
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_coord      <= '0;
        i_last_coord <= 1'b0;
        i_out_ready  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_THRESHOLD;
        i_cfg_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: coordinate extremes, exact repeat absorb,
        // missing coordinates, extra coordinates past counter saturation.
        send_word(32'h7FFF_FFFF, 0); send_word(32'h8000_0000, 1);
        send_word(32'h7FFF_FFFF, 0); send_word(32'h8000_0000, 1);
        send_word(32'h0000_0000, 1);
        for (k = 0; k < 16; k++) send_word(32'h0001_0000, 0);
        send_word(32'h0001_0000, 1);
        send_word(32'h8000_0000, 0); send_word(32'h7FFF_FFFF, 1);
        send_word(32'h0000_8000, 0); send_word(32'h0000_0000, 1);
        send_word(32'hFFFF_FFFF, 0); send_word(32'h0000_0001, 1);

        // Top extremes: widest limit, clamped dims, widest radius.
        write_reg(CFG_MAX_ENTRIES, 32'h0000_03FF);
        write_reg(CFG_DIMS, 32'h0000_000F);
        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
        for (k = 0; k < 8; k++) send_word($urandom(), k == 7);
        send_word(32'h8000_0000, 1);

        // Bottom extremes, then overflow the table once to force a rebuild.
        write_reg(CFG_THRESHOLD, 32'h0000_0000);
        write_reg(CFG_MAX_ENTRIES, 32'h0000_0000);
        write_reg(CFG_DIMS, 32'h0000_0000);
        for (k = 0; k < 97; k++) send_word(32'h4000_0000 - k * 32'h0010_0000, 1);
        send_word(32'h4000_0000, 1);

        // Random phases across the idling modes; keep the limit high so the
        // table never rebuilds again.
        write_reg(CFG_MAX_ENTRIES, 32'd1023);
        write_reg(CFG_DIMS, 32'd2);
        write_reg(CFG_THRESHOLD, 32'h0000_4000);
        send_gap_pct = 0;  recv_stall_pct = 0;
        random_points(6);

        send_gap_pct = 45; recv_stall_pct = 0;
        random_points(6);

        write_reg(CFG_DIMS, 32'd3);
        write_reg(CFG_THRESHOLD, 32'h0002_0000);
        send_gap_pct = 0;  recv_stall_pct = 45;
        random_points(6);

        // long receiver hold-off with the sender still pushing
        hold_req = 1;
        send_gap_pct = 0;  recv_stall_pct = 0;
        random_points(18);

        write_reg(CFG_DIMS, 32'd8);
        write_reg(CFG_THRESHOLD, 32'd655);
        send_gap_pct = 14; recv_stall_pct = 14;
        random_points(6);

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            if (sb.pending_q.size() != 0)
                $error("%0d results never arrived", sb.pending_q.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
